@@ design/bicubic_patch_interpolator_top_assert.svh @@
// assertion macros used by the checker file
`ifndef BICUBIC_PATCH_INTERPOLATOR_TOP_ASSERT_SVH
`define BICUBIC_PATCH_INTERPOLATOR_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define BPI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define BPI_ASSERT_NXT(lbl, clk, ante, cons, msg, rst_n) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, also checked while reset is applied
`define BPI_ASSERT_RST(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/bpi_pkg.sv @@
package bpi_pkg;

    // fixed field widths of the ports
    localparam int COL_BITS      = 64;
    localparam int FRAC_IN_BITS  = 16;
    localparam int OUT_BITS      = 17;

    // parameter defaults
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF   = 16;

    // patch geometry
    localparam int NUM_TAPS = 4;

    // register stages of one cubic evaluation, and of the whole pipe
    localparam int CUBIC_STAGES = 7;
    localparam int PIPE_STAGES  = 2 * CUBIC_STAGES + 1;

endpackage

@@ design/bpi_cubic.sv @@
module bpi_cubic import bpi_pkg::*; #(
    parameter int IN_BITS   = SAMPLE_BITS_DEF + FRAC_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic [CUBIC_STAGES-1:0]     en,
    input  logic signed [IN_BITS-1:0]   v0,
    input  logic signed [IN_BITS-1:0]   v1,
    input  logic signed [IN_BITS-1:0]   v2,
    input  logic signed [IN_BITS-1:0]   v3,
    input  logic [FRAC_BITS-1:0]        t,
    output logic signed [IN_BITS:0]     y
);

    // working width holds the 12x coefficient sums plus Horner growth
    localparam int WI = IN_BITS + 7;
    localparam int PW = WI + FRAC_BITS + 1;
    localparam logic signed [PW-1:0] HALF      = PW'(1) << (FRAC_BITS - 1);
    localparam logic signed [PW-1:0] HALF_LAST = PW'(1) << FRAC_BITS;

    logic signed [WI-1:0] e0, e1, e2, e3;
    logic signed [WI-1:0] a_next, b_next, c_next;
    logic signed [WI-1:0] a0_reg, a1_reg, a2_reg, a3_reg;
    logic signed [WI-1:0] b0_reg, b1_reg;
    logic signed [WI-1:0] c0_reg;
    logic signed [WI-1:0] m0_reg, m1_reg, m2_reg, m3_reg, m4_reg, m5_reg;
    logic [FRAC_BITS-1:0] t0_reg, t1_reg, t2_reg, t3_reg, t4_reg;
    logic signed [PW-1:0] p1_next, p1_reg, p2_next, p2_reg, p3_next, p3_reg;
    logic signed [PW-1:0] p1_rnd, p2_rnd, p3_rnd;
    logic signed [WI-1:0] inner_next, inner_reg, mid_next, mid_reg, y_next;
    logic signed [IN_BITS:0] y_reg;

    // stage 0: coefficient sums
    assign e0 = WI'(v0);
    assign e1 = WI'(v1);
    assign e2 = WI'(v2);
    assign e3 = WI'(v3);
    assign a_next = e2 - e0;
    assign b_next = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
    assign c_next = (e1 <<< 1) + e1 - (e2 <<< 1) - e2 + e3 - e0;

    // stage 1: t * c
    assign p1_next = $signed({1'b0, t0_reg}) * c0_reg;

    // stage 2: inner = b + round(t * c)
    assign p1_rnd     = (p1_reg + HALF) >>> FRAC_BITS;
    assign inner_next = b1_reg + $signed(p1_rnd[WI-1:0]);

    // stage 3: t * inner
    assign p2_next = $signed({1'b0, t2_reg}) * inner_reg;

    // stage 4: mid = a + round(t * inner)
    assign p2_rnd   = (p2_reg + HALF) >>> FRAC_BITS;
    assign mid_next = a3_reg + $signed(p2_rnd[WI-1:0]);

    // stage 5: t * mid
    assign p3_next = $signed({1'b0, t4_reg}) * mid_reg;

    // stage 6: v1 + round(t * mid / 2)
    assign p3_rnd = (p3_reg + HALF_LAST) >>> (FRAC_BITS + 1);
    assign y_next = m5_reg + $signed(p3_rnd[WI-1:0]);

    // pipeline registers, each stage loads on its own enable
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            a0_reg <= a_next;
            b0_reg <= b_next;
            c0_reg <= c_next;
            m0_reg <= e1;
            t0_reg <= t;
        end
        if (en[1]) begin
            p1_reg <= p1_next;
            a1_reg <= a0_reg;
            b1_reg <= b0_reg;
            m1_reg <= m0_reg;
            t1_reg <= t0_reg;
        end
        if (en[2]) begin
            inner_reg <= inner_next;
            a2_reg    <= a1_reg;
            m2_reg    <= m1_reg;
            t2_reg    <= t1_reg;
        end
        if (en[3]) begin
            p2_reg <= p2_next;
            a3_reg <= a2_reg;
            m3_reg <= m2_reg;
            t3_reg <= t2_reg;
        end
        if (en[4]) begin
            mid_reg <= mid_next;
            m4_reg  <= m3_reg;
            t4_reg  <= t3_reg;
        end
        if (en[5]) begin
            p3_reg <= p3_next;
            m5_reg <= m4_reg;
        end
        if (en[6]) begin
            y_reg <= $signed(y_next[IN_BITS:0]);
        end
    end

    assign y = y_reg;

endmodule

@@ design/bicubic_patch_interpolator_top.sv @@
// Catmull-Rom bicubic interpolator, fully pipelined over 15 register stages.
// Throughput: one patch per cycle while the output is not stalled.
// Each cubic pass is seven stages, three of them multiply.
// Per-stage valid bits let bubbles close up under output stall.
// Reset (aresetn low, synchronous) clears all valid bits; data registers are not reset.
module bicubic_patch_interpolator_top import bpi_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [COL_BITS-1:0]         s_column_0,
    input  logic [COL_BITS-1:0]         s_column_1,
    input  logic [COL_BITS-1:0]         s_column_2,
    input  logic [COL_BITS-1:0]         s_column_3,
    input  logic [FRAC_IN_BITS-1:0]     s_frac_x,
    input  logic [FRAC_IN_BITS-1:0]     s_frac_y,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [OUT_BITS-1:0]  m_pixel_value
);

    localparam int VW = SAMPLE_BITS + FRAC_BITS;
    localparam int CW = VW + 1;
    localparam int XW = CW + 1;
    localparam int EW = XW + OUT_BITS;
    localparam logic signed [EW-1:0] HALF = EW'(1) << (FRAC_BITS - 1);

    logic [COL_BITS-1:0]    col_in [NUM_TAPS];
    logic signed [VW-1:0]   samp [NUM_TAPS][NUM_TAPS];
    logic signed [CW-1:0]   col_out [NUM_TAPS];
    logic signed [XW-1:0]   x_out;
    logic [PIPE_STAGES-1:0] vld_reg, vld_next, rdy, en;
    logic [FRAC_BITS-1:0]   fx_reg [CUBIC_STAGES];
    logic signed [EW-1:0]   x_ext, x_rnd;
    logic signed [OUT_BITS-1:0] pix_next, pix_reg;

    assign col_in[0] = s_column_0;
    assign col_in[1] = s_column_1;
    assign col_in[2] = s_column_2;
    assign col_in[3] = s_column_3;

    // ready ripples back from the output, valid bits move forward
    always_comb begin
        rdy[PIPE_STAGES-1] = !vld_reg[PIPE_STAGES-1] || m_ready;
        for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        en = rdy & {vld_reg[PIPE_STAGES-2:0], s_valid};
        vld_next = en | (~rdy & vld_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_ready = rdy[0];
    assign m_valid = vld_reg[PIPE_STAGES-1];

    // vertical pass: one cubic per column, samples scaled to fixed point
    for (genvar i = 0; i < NUM_TAPS; i++) begin : g_col
        for (genvar k = 0; k < NUM_TAPS; k++) begin : g_samp
            assign samp[i][k] = $signed({col_in[i][k*SAMPLE_BITS +: SAMPLE_BITS],
                                         {FRAC_BITS{1'b0}}});
        end
        bpi_cubic #(
            .IN_BITS   (VW),
            .FRAC_BITS (FRAC_BITS)
        ) u_ypass (
            .aclk (aclk),
            .en   (en[CUBIC_STAGES-1:0]),
            .v0   (samp[i][0]),
            .v1   (samp[i][1]),
            .v2   (samp[i][2]),
            .v3   (samp[i][3]),
            .t    (s_frac_y[FRAC_BITS-1:0]),
            .y    (col_out[i])
        );
    end

    // horizontal fraction rides along with the vertical pass
    always_ff @(posedge aclk) begin
        for (int k = 0; k < CUBIC_STAGES; k++) begin
            if (en[k]) begin
                fx_reg[k] <= (k == 0) ? s_frac_x[FRAC_BITS-1:0] : fx_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    // horizontal pass over the four column results
    bpi_cubic #(
        .IN_BITS   (CW),
        .FRAC_BITS (FRAC_BITS)
    ) u_xpass (
        .aclk (aclk),
        .en   (en[2*CUBIC_STAGES-1:CUBIC_STAGES]),
        .v0   (col_out[0]),
        .v1   (col_out[1]),
        .v2   (col_out[2]),
        .v3   (col_out[3]),
        .t    (fx_reg[CUBIC_STAGES-1]),
        .y    (x_out)
    );

    // back to sample units, rounded to nearest
    assign x_ext    = EW'(x_out);
    assign x_rnd    = (x_ext + HALF) >>> FRAC_BITS;
    assign pix_next = $signed(x_rnd[OUT_BITS-1:0]);

    always_ff @(posedge aclk) begin
        if (en[PIPE_STAGES-1]) begin
            pix_reg <= pix_next;
        end
    end

    assign m_pixel_value = pix_reg;

endmodule

@@ design/bpi_checker.sv @@
`include "bicubic_patch_interpolator_top_assert.svh"

module bpi_checker import bpi_pkg::*; (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic signed [OUT_BITS-1:0]  m_pixel_value
);

    // a stalled result stays offered
    `BPI_ASSERT_NXT(a_hold_valid, aclk, m_valid && !m_ready, m_valid, "result dropped under stall", aresetn)

    // a stalled result keeps its value
    `BPI_ASSERT_NXT(a_hold_data, aclk, m_valid && !m_ready, $stable(m_pixel_value), "result changed under stall", aresetn)

    // with the sink ready the pipe never back-pressures the source
    `BPI_ASSERT_IMP(a_no_bp, aclk, aresetn, m_ready, s_ready, "input stalled while output ready")

    // reset empties the pipe
    `BPI_ASSERT_RST(a_reset_empty, aclk, !aresetn, !m_valid, "result offered after reset")

endmodule

bind bicubic_patch_interpolator_top bpi_checker u_bpi_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_pixel_value (m_pixel_value)
);
